/* src/sch_pkg.sv */
`default_nettype none

package sch_pkg;

   localparam int MAP_W             = 37;
   localparam int PRN_W             = 16;
   localparam int CHAN_W            = 6;
   localparam int SE_W              = 5;
   localparam int MUL_B_W           = 17;
   localparam int PROD_W            = PRN_W + MUL_B_W;
   localparam int DEF_NUM_CHANNELS  = 37;
   localparam int DEF_MAX_SUBEVENTS = 31;

   localparam logic [MUL_B_W-1:0] MAM_MULT     = MUL_B_W'(17);
   localparam logic [MAP_W-1:0]   MAP_RESET    = {MAP_W{1'b1}};

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MAP_W;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MAP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ID  = CSR_IDX_W'(1);

   // Reverses the bit order inside each of the two bytes.
   function automatic logic [PRN_W-1:0] rev_bytes(input logic [PRN_W-1:0] x);
      logic [PRN_W-1:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         r[7 - b]  = x[b];
         r[15 - b] = x[8 + b];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/sch_ram.sv */
`default_nettype none

module sch_ram
   #(parameter int WIDTH = 6,
     parameter int DEPTH = 37)
   (input  wire logic                     clock,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/subevent_channel_hopper.sv */
`default_nettype none
// A request, once accepted, goes through 3 hash rounds, a reciprocal modulo (quotient, then remainder),
// a scan of the map for the used list, then remap, list read and load, to give its first result.
// Each further subevent, after the previous result is taken, takes a PRN step, multiply,
// add-and-wrap, list read and load, or only list read and load with an invalid map. The shared 16x17
// multiplier and the list RAM set this sequence. One request is in flight at a time. Reset
// (synchronous, active high) marks all channels used, clears the identifier and goes idle.

module subevent_channel_hopper
   import sch_pkg::*;
   #(parameter int NUM_CHANNELS  = DEF_NUM_CHANNELS,
     parameter int MAX_SUBEVENTS = DEF_MAX_SUBEVENTS)
   (input  wire logic                  clock,
    input  wire logic                  reset,
    input  wire logic                  req_tvalid,
    output logic                       req_tready,
    input  wire logic [23:0]           req_tdata,   // event_counter[15:0], subevent_count[20:16]
    output logic                       rsp_tvalid,
    input  wire logic                  rsp_tready,
    output logic      [15:0]           rsp_tdata,   // channel[5:0], subevent_number[10:6]
    output logic                       rsp_tlast,
    output logic                       rsp_tuser,   // map_invalid
    input  wire logic                  csr_we,
    input  wire logic [CSR_IDX_W-1:0]  csr_index,
    input  wire logic [CSR_DATA_W-1:0] csr_wdata);

   localparam int IDX_W   = $clog2(NUM_CHANNELS);
   localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
   localparam int SCAN_N  = (NUM_CHANNELS < MAP_W) ? NUM_CHANNELS : MAP_W;
   localparam int MAX_EFF = (MAX_SUBEVENTS < 31) ? MAX_SUBEVENTS : 31;

   // The reciprocal is rounded up; with this shift the quotient is exact for any 16-bit value.
   localparam int MOD_SHIFT = PRN_W + $clog2(NUM_CHANNELS);
   localparam logic [MUL_B_W-1:0] MOD_RECIP =
      MUL_B_W'(((longint'(1) << MOD_SHIFT) + longint'(NUM_CHANNELS - 1)) /
               longint'(NUM_CHANNELS));

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_HASH    = 4'd1;
   localparam logic [3:0] S_MOD     = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_REMAP   = 4'd4;
   localparam logic [3:0] S_READ    = 4'd5;
   localparam logic [3:0] S_LOAD    = 4'd6;
   localparam logic [3:0] S_OUT     = 4'd7;
   localparam logic [3:0] S_HOP_PRN = 4'd8;
   localparam logic [3:0] S_HOP_OFS = 4'd9;
   localparam logic [3:0] S_HOP_ADD = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [MAP_W-1:0]   map_ff, map_in;
   logic [PRN_W-1:0]   id_ff, id_in;
   logic [PRN_W-1:0]   prn_ff, prn_in;
   logic [PRN_W-1:0]   quo_ff, quo_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [MAP_W-1:0]   smap_ff, smap_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MUL_B_W-1:0] ofs_ff, ofs_in;
   logic [SE_W-1:0]    nse_ff, nse_in;
   logic [SE_W-1:0]    k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic [SE_W-1:0]    rsp_num_ff, rsp_num_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_inv_ff, rsp_inv_in;

   logic [PRN_W-1:0]   mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [PRN_W-1:0]   mam;
   logic [7:0]         n8;
   logic [3:0]         hop_dist;
   logic [MUL_B_W-1:0] span;
   logic [7:0]         hop_sum;
   logic [IDX_W-1:0]   hop_idx;
   logic               invalid;
   logic [SE_W-1:0]    req_nse;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [CHAN_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [CHAN_W-1:0]  ram_rdata;

   sch_ram #(.WIDTH(CHAN_W), .DEPTH(NUM_CHANNELS)) u_used_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata));

   // One multiplier serves the hash rounds, the modulo, the remap scaling and the offset.
   always_comb begin
      unique case (state_ff)
         S_HASH, S_HOP_PRN: begin
            mul_a = rev_bytes(prn_ff);
            mul_b = MAM_MULT;
         end
         S_MOD: begin
            // First the quotient by reciprocal, then quotient times the channel count.
            if (cnt_ff == 4'd0) begin
               mul_a = prn_ff ^ id_ff;
               mul_b = MOD_RECIP;
            end else begin
               mul_a = quo_ff;
               mul_b = MUL_B_W'(NUM_CHANNELS);
            end
         end
         S_REMAP: begin
            mul_a = prn_ff ^ id_ff;
            mul_b = MUL_B_W'(n_ff);
         end
         S_HOP_OFS: begin
            mul_a = prn_ff ^ id_ff;
            mul_b = span;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign mam   = mul_p[PRN_W-1:0] + id_ff;

   assign n8      = 8'(n_ff);
   assign invalid = (n8 < 8'd2);

   always_comb begin
      logic [3:0] da;
      logic [3:0] db;
      if (n8 >= 8'd8) begin
         da = 4'd3;
      end else if (n8 >= 8'd6) begin
         da = 4'(n8 - 8'd5);
      end else begin
         da = 4'd0;
      end
      if (n8 >= 8'd32) begin
         db = 4'd11;
      end else if (n8 >= 8'd10) begin
         db = 4'((n8 - 8'd10) >> 1);
      end else begin
         db = 4'd0;
      end
      hop_dist = 4'd1;
      if (da > hop_dist) begin
         hop_dist = da;
      end
      if (db > hop_dist) begin
         hop_dist = db;
      end
   end

   assign span    = MUL_B_W'(n8 - {3'b0, hop_dist, 1'b0} + 8'd1);
   // The sum stays below twice the channel count, so one subtraction wraps it.
   assign hop_sum = 8'(idx_ff) + 8'(hop_dist) + 8'(ofs_ff);
   assign hop_idx = (hop_sum >= n8) ? IDX_W'(hop_sum - n8) : IDX_W'(hop_sum);

   always_comb begin
      req_nse = req_tdata[20:16];
      if (req_nse == '0) begin
         req_nse = SE_W'(1);
      end else if (req_nse > SE_W'(MAX_EFF)) begin
         req_nse = SE_W'(MAX_EFF);
      end
   end

   always_comb begin
      state_in     = state_ff;
      map_in       = map_ff;
      id_in        = id_ff;
      prn_in       = prn_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      smap_in      = smap_ff;
      n_in         = n_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      idx_in       = idx_ff;
      ofs_in       = ofs_ff;
      nse_in       = nse_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_inv_in   = rsp_inv_ff;
      ram_we       = 1'b0;
      ram_waddr    = n_ff[IDX_W-1:0];
      ram_wdata    = CHAN_W'(scan_ff);
      ram_re       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_MAP: map_in = csr_wdata[MAP_W-1:0];
            CSR_CHANNEL_ID:  id_in  = csr_wdata[PRN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               prn_in   = req_tdata[PRN_W-1:0] ^ id_ff;
               nse_in   = req_nse;
               cnt_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            prn_in = mam;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd0) begin
               quo_in = PRN_W'(mul_p >> MOD_SHIFT);
            end else begin
               rem_in   = IDX_W'((prn_ff ^ id_ff) - mul_p[PRN_W-1:0]);
               scan_in  = '0;
               smap_in  = map_ff;
               n_in     = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (smap_ff[0]) begin
               ram_we = 1'b1;
               n_in   = n_ff + CNT_W'(1);
               if (scan_ff == rem_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = n_ff[IDX_W-1:0];
               end
            end
            smap_in = smap_ff >> 1;
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(SCAN_N - 1)) begin
               state_in = S_REMAP;
            end
         end
         S_REMAP: begin
            // A used channel keeps its own slot; an unused one is scaled into the list; an invalid map gives slot zero.
            if (invalid) begin
               idx_in = '0;
            end else if (found_ff) begin
               idx_in = found_idx_ff;
            end else begin
               idx_in = IDX_W'(mul_p[PROD_W-1:PRN_W]);
            end
            k_in     = '0;
            state_in = S_READ;
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rsp_chan_in  = invalid ? '0 : ram_rdata;
            rsp_num_in   = k_ff;
            rsp_last_in  = (k_ff == nse_ff - SE_W'(1));
            rsp_inv_in   = invalid;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + SE_W'(1);
                  state_in = invalid ? S_READ : S_HOP_PRN;
               end
            end
         end
         S_HOP_PRN: begin
            prn_in   = mam;
            state_in = S_HOP_OFS;
         end
         S_HOP_OFS: begin
            ofs_in   = mul_p[PROD_W-1:PRN_W];
            state_in = S_HOP_ADD;
         end
         S_HOP_ADD: begin
            idx_in   = hop_idx;
            state_in = S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         map_ff       <= MAP_RESET;
         id_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         id_ff        <= id_in;
      end
   end

   always_ff @(posedge clock) begin
      prn_ff       <= prn_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      scan_ff      <= scan_in;
      smap_ff      <= smap_in;
      n_ff         <= n_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      idx_ff       <= idx_in;
      ofs_ff       <= ofs_in;
      nse_ff       <= nse_in;
      k_ff         <= k_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_inv_ff   <= rsp_inv_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_num_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_inv_ff;

endmodule

`default_nettype wire

/* src/sch_checker.sv */
`default_nettype none

module sch_checker
   (input wire logic        clock,
    input wire logic        reset,
    input wire logic        req_tvalid,
    input wire logic        req_tready,
    input wire logic        rsp_tvalid,
    input wire logic        rsp_tready,
    input wire logic [15:0] rsp_tdata,
    input wire logic        rsp_tlast,
    input wire logic        rsp_tuser);

   // A held result keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The block is busy right after it takes a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again right after a request");

   // No new request is taken while a result is pending.
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while a result is pending");

   // More subevents follow a result that is not the last one.
   a_more_after_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("request taken before the last subevent");

   // An unusable channel map always reports channel zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[5:0] == 6'd0)
      else $error("nonzero channel with an invalid map");

endmodule

bind subevent_channel_hopper sch_checker u_sch_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser));

`default_nettype wire

/* tb/subevent_channel_hopper_tb.sv */
`timescale 1ns / 1ps

module subevent_channel_hopper_tb;
   import sch_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = CSR_IDX_W'(3);
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_PRINTED = 50;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [SE_W-1:0]   subevent_number;
      logic              last;
      logic              map_invalid;
   } hop_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // event_counter[15:0], subevent_count[20:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;        // channel[5:0], subevent_number[10:6]
   logic                  rsp_tlast;
   logic                  rsp_tuser;        // map_invalid
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copies of the block's registers, as they stand after reset.
   logic [MAP_W-1:0] model_map = MAP_RESET;
   logic [PRN_W-1:0] model_id = '0;

   hop_type expected_hops[$];
   int   mismatch_count = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_cycles = 0;

   subevent_channel_hopper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Flipping the low three index bits mirrors the bit order inside each byte.
   function automatic logic [PRN_W-1:0] mirror_bytes(input logic [PRN_W-1:0] v);
      logic [PRN_W-1:0] r;
      for (int b = 0; b < PRN_W; b++)
         r[b ^ 7] = v[b];
      return r;
   endfunction

   function automatic logic [PRN_W-1:0] scramble_round(input logic [PRN_W-1:0] v,
                                                       input logic [PRN_W-1:0] id);
      logic [31:0] t;
      t = 32'd17 * mirror_bytes(v) + id;
      return t[PRN_W-1:0];
   endfunction

   task automatic predict_hops(input logic [15:0] counter, input logic [4:0] count);
      int               used[DEF_NUM_CHANNELS];
      int               n, nse, lo, hi, d, idx, span, offset;
      logic             invalid;
      logic [PRN_W-1:0] prn, prn_e, prn_se;
      hop_type          h;
      nse = (count == 0) ? 1 : int'(count);
      if (nse > DEF_MAX_SUBEVENTS)
         nse = DEF_MAX_SUBEVENTS;
      n = 0;
      for (int ch = 0; ch < DEF_NUM_CHANNELS; ch++) begin
         if (model_map[ch]) begin
            used[n] = ch;
            n++;
         end
      end
      invalid = (n < 2);

      prn = counter ^ model_id;
      repeat (3) prn = scramble_round(prn, model_id);
      prn_e = prn ^ model_id;

      lo = n - 5;
      if (lo > 3)
         lo = 3;
      hi = (n - 10) / 2;
      if (hi > 11)
         hi = 11;
      d = (lo > hi) ? lo : hi;
      if (d < 1)
         d = 1;

      // The event channel stands if it is used; otherwise it is remapped by scaling.
      idx = 0;
      if (!invalid) begin
         idx = (n * int'(prn_e)) >> 16;
         for (int i = 0; i < n; i++) begin
            if (used[i] == int'(prn_e) % DEF_NUM_CHANNELS)
               idx = i;
         end
      end

      for (int k = 0; k < nse; k++) begin
         if (k > 0 && !invalid) begin
            prn = scramble_round(prn, model_id);
            prn_se = prn ^ model_id;
            span = n - 2 * d + 1;
            offset = (int'(prn_se) * span) >> 16;
            idx = (idx + d + offset) % n;
         end
         h.channel = invalid ? '0 : CHAN_W'(used[idx]);
         h.subevent_number = SE_W'(k);
         h.last = (k == nse - 1);
         h.map_invalid = invalid;
         expected_hops.push_back(h);
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      hop_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hops.size() == 0) begin
            report_mismatch($sformatf("unexpected result, data %h", rsp_tdata));
         end else begin
            want = expected_hops.pop_front();
            if (rsp_tdata[5:0] !== want.channel)
               report_mismatch($sformatf("channel %0d, expected %0d (subevent %0d)",
                                         rsp_tdata[5:0], want.channel,
                                         want.subevent_number));
            if (rsp_tdata[10:6] !== want.subevent_number)
               report_mismatch($sformatf("subevent_number %0d, expected %0d",
                                         rsp_tdata[10:6], want.subevent_number));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b, expected %b (subevent %0d)",
                                         rsp_tlast, want.last, want.subevent_number));
            if (rsp_tuser !== want.map_invalid)
               report_mismatch($sformatf("map_invalid %b, expected %b (subevent %0d)",
                                         rsp_tuser, want.map_invalid,
                                         want.subevent_number));
         end
      end
   end

   task automatic send_request(input logic [15:0] counter, input logic [4:0] count);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, count, counter};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_hops(counter, count);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_hops.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_CHANNEL_MAP)
         model_map = value[MAP_W-1:0];
      else if (index == CSR_CHANNEL_ID)
         model_id = value[PRN_W-1:0];
   endtask

   task automatic set_config(input logic [MAP_W-1:0] map, input logic [PRN_W-1:0] id);
      wait_for_drain();
      write_register(CSR_CHANNEL_MAP, CSR_DATA_W'(map));
      write_register(CSR_CHANNEL_ID, CSR_DATA_W'(id));
   endtask

   function automatic logic [MAP_W-1:0] random_channel_map();
      logic [MAP_W-1:0] m;
      int               picks;
      case ($urandom_range(0, 5))
         0: m = MAP_RESET;
         1: m = MAP_W'({$urandom(), $urandom()});
         2: m = MAP_W'({$urandom(), $urandom()}) & MAP_W'({$urandom(), $urandom()});
         3: m = MAP_W'({$urandom(), $urandom()}) | MAP_W'({$urandom(), $urandom()});
         4: begin
            m = '0;
            m[$urandom_range(0, 18)] = 1'b1;
            m[$urandom_range(19, 36)] = 1'b1;
         end
         default: begin
            m = '0;
            picks = $urandom_range(0, 6);
            repeat (picks) m[$urandom_range(0, 36)] = 1'b1;
         end
      endcase
      return m;
   endfunction

   // Mostly short events keep the run quick; now and then any count, zero included.
   function automatic logic [4:0] random_count();
      if ($urandom_range(0, 5) == 0)
         return 5'($urandom_range(0, 31));
      return 5'($urandom_range(1, 8));
   endfunction

   task automatic test_reset_defaults();
      send_request(16'h0000, 5'd1);
      send_request(16'hFFFF, 5'd31);
      send_request(16'h1234, 5'd0);
   endtask

   task automatic test_identifier_extremes();
      set_config(MAP_RESET, 16'hFFFF);
      send_request(16'h0000, 5'd5);
      send_request(16'hFFFF, 5'd1);
      send_request(16'h8001, 5'd31);
   endtask

   task automatic test_sparse_maps();
      // Two used channels at the ends of the band is the smallest valid map.
      set_config(37'h10_0000_0001, 16'hA5C3);
      send_request(16'h0007, 5'd4);
      send_request(16'hFFFF, 5'd3);
      // A single used channel and an empty map are both invalid.
      set_config(37'h00_0002_0000, 16'h0F0F);
      send_request(16'h0009, 5'd3);
      set_config('0, 16'h0F0F);
      send_request(16'h0000, 5'd2);
      set_config(37'h00_0000_03FF, 16'h3C96);
      send_request(16'h5555, 5'd6);
      // Every other channel unused forces the remap path often.
      set_config(37'h0A_AAAA_AAAA, 16'h8E89);
      send_request(16'h0001, 5'd6);
      send_request(16'hAAAA, 5'd6);
      send_request(16'h7FFF, 5'd6);
   endtask

   task automatic test_unused_register_index();
      set_config(MAP_RESET, 16'h1111);
      write_register(CSR_UNUSED_A, '0);
      write_register(CSR_UNUSED_B, '1);
      send_request(16'd42, 5'd4);
   endtask

   task automatic test_backpressure();
      set_config(random_channel_map() | 37'h00_0000_00FF, 16'($urandom_range(0, 65535)));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // The receiver holds off long enough for the block to stall its input.
      hold_cycles = 500;
      for (int i = 0; i < 6; i++)
         send_request(16'($urandom_range(0, 65535)), 5'($urandom_range(3, 8)));
      wait_for_drain();
      rsp_stall_pct = 64;
      for (int i = 0; i < 4; i++)
         send_request(16'($urandom_range(0, 65535)), random_count());
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      int send_pct[4];
      int stall_pct[4];
      send_pct = '{0, 64, 0, 24};
      stall_pct = '{0, 0, 64, 24};
      for (int p = 0; p < 4; p++) begin
         for (int c = 0; c < 2; c++) begin
            set_config(random_channel_map(), 16'($urandom_range(0, 65535)));
            send_idle_pct = send_pct[p];
            rsp_stall_pct = stall_pct[p];
            for (int j = 0; j < 11; j++)
               send_request(16'($urandom_range(0, 65535)), random_count());
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_identifier_extremes();
      test_sparse_maps();
      test_unused_register_index();
      test_backpressure();
      test_random_traffic();
      wait_for_drain();
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
